FILE: design/sms_pkg.sv
// shared constants and control/status types for the stable merge sorter
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

  localparam int unsigned MaxElements = 8;
  localparam int unsigned DataWidth   = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // write the input value, bump the count
    logic sort_start;  // width 1, first group, bank 0 as source
    logic group_init;  // set up the two runs of the current group
    logic merge_step;  // move one element into the other bank
    logic next_group;  // advance to the following group
    logic next_pass;   // double the width, swap banks
    logic end_sort;    // swap banks after the final pass
    logic emit_sel;    // read port a follows the output index
    logic emit_out;    // load the output register, bump the index
    logic clear;       // empty the list
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic load_end;    // the store is one short of full
    logic single;      // only one element held
    logic group_last;  // this step writes the last slot of the group
    logic pass_last;   // current group reaches the end of the list
    logic sort_done;   // no further pass needed
    logic emit_last;   // next output is the final one
    logic out_busy;    // output register holds a result not yet taken
  } status_t;

endpackage

`default_nettype wire

FILE: design/sms_ctrl.sv
// controller state machine for the stable merge sorter
`timescale 1ns / 1ps
`default_nettype none

module sms_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_last_i,
  output logic                 in_ready_o,
  input  wire sms_pkg::status_t status_i,
  output sms_pkg::cmd_t        cmd_o
);

  localparam logic [2:0] SLoad  = 3'd0;
  localparam logic [2:0] SStart = 3'd1;
  localparam logic [2:0] SGinit = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SMerge = 3'd4;
  localparam logic [2:0] SEread = 3'd5;
  localparam logic [2:0] SEmit  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i || status_i.load_end) begin
            state_d = SStart;
          end
        end
      end
      SStart: begin
        cmd_o.sort_start = 1'b1;
        state_d = status_i.single ? SEread : SGinit;
      end
      SGinit: begin
        cmd_o.group_init = 1'b1;
        state_d = SRead;
      end
      SRead: begin
        state_d = SMerge;
      end
      SMerge: begin
        cmd_o.merge_step = 1'b1;
        priority if (!status_i.group_last) begin
          state_d = SRead;
        end else if (!status_i.pass_last) begin
          cmd_o.next_group = 1'b1;
          state_d = SGinit;
        end else if (!status_i.sort_done) begin
          cmd_o.next_pass = 1'b1;
          state_d = SGinit;
        end else begin
          cmd_o.end_sort = 1'b1;
          state_d = SEread;
        end
      end
      SEread: begin
        cmd_o.emit_sel = 1'b1;
        state_d = SEmit;
      end
      SEmit: begin
        cmd_o.emit_sel = 1'b1;
        if (!status_i.out_busy) begin
          cmd_o.emit_out = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d = SLoad;
          end else begin
            state_d = SEread;
          end
        end
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sms_datapath.sv
// two-bank element memory, merge counters, comparator and output register
`timescale 1ns / 1ps
`default_nettype none

module sms_datapath #(
  parameter int unsigned MAX_ELEMENTS = sms_pkg::MaxElements
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire sms_pkg::cmd_t                    cmd_i,
  output sms_pkg::status_t                      status_o,
  input  wire logic [sms_pkg::DataWidth-1:0]    in_value_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [sms_pkg::DataWidth-1:0]         out_value_o,
  output logic                                  out_final_o
);

  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned WW    = CW + 2;
  localparam int unsigned Depth = 2 * (2 ** IW);
  localparam int unsigned DW    = sms_pkg::DataWidth;

  logic [CW-1:0] cnt_q, cnt_d, w_q, w_d, lo_q, lo_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, mid_q, mid_d, hi_q, hi_d, k_q, k_d;
  logic [CW-1:0] oidx_q, oidx_d;
  logic          src_q, src_d;
  logic          out_valid_q, out_valid_d;

  logic [DW-1:0] mem [Depth];
  logic [DW-1:0] rd_a_q, rd_b_q;
  logic [DW-1:0] out_value_q;
  logic          out_final_q;

  logic [WW-1:0] lo_w, w_w, n_w, sum_mid, sum_hi;
  logic [CW-1:0] mid_new, hi_new;
  logic          take_a;
  logic [DW-1:0] merge_data, wr_data;
  logic [IW:0]   addr_a, addr_b, wr_addr;
  logic          wr_en;

  assign lo_w    = WW'(lo_q);
  assign w_w     = WW'(w_q);
  assign n_w     = WW'(cnt_q);
  assign sum_mid = lo_w + w_w;
  assign sum_hi  = lo_w + (w_w << 1);
  assign mid_new = (sum_mid > n_w) ? cnt_q : sum_mid[CW-1:0];
  assign hi_new  = (sum_hi > n_w) ? cnt_q : sum_hi[CW-1:0];

  // left run wins on equal keys
  assign take_a = (a_q < mid_q) &&
                  ((b_q >= hi_q) || ($signed(rd_a_q) <= $signed(rd_b_q)));
  assign merge_data = take_a ? rd_a_q : rd_b_q;

  assign addr_a  = {src_q, cmd_i.emit_sel ? oidx_q[IW-1:0] : a_q[IW-1:0]};
  assign addr_b  = {src_q, b_q[IW-1:0]};
  assign wr_en   = cmd_i.load | cmd_i.merge_step;
  assign wr_addr = cmd_i.load ? {1'b0, cnt_q[IW-1:0]} : {~src_q, k_q[IW-1:0]};
  assign wr_data = cmd_i.load ? in_value_i : merge_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_comb begin
    cnt_d       = cnt_q;
    w_d         = w_q;
    lo_d        = lo_q;
    a_d         = a_q;
    b_d         = b_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    k_d         = k_q;
    oidx_d      = oidx_q;
    src_d       = src_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.load) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.sort_start) begin
      w_d   = CW'(1);
      lo_d  = '0;
      src_d = 1'b0;
    end
    if (cmd_i.group_init) begin
      a_d   = lo_q;
      mid_d = mid_new;
      b_d   = mid_new;
      hi_d  = hi_new;
      k_d   = lo_q;
    end
    if (cmd_i.merge_step) begin
      k_d = k_q + CW'(1);
      if (take_a) begin
        a_d = a_q + CW'(1);
      end else begin
        b_d = b_q + CW'(1);
      end
    end
    if (cmd_i.next_group) begin
      lo_d = hi_q;
    end
    if (cmd_i.next_pass) begin
      w_d   = w_q << 1;
      lo_d  = '0;
      src_d = ~src_q;
    end
    if (cmd_i.end_sort) begin
      src_d = ~src_q;
    end
    if (cmd_i.emit_out) begin
      oidx_d      = oidx_q + CW'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.clear) begin
      cnt_d  = '0;
      oidx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      w_q         <= '0;
      lo_q        <= '0;
      a_q         <= '0;
      b_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      oidx_q      <= '0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      w_q         <= w_d;
      lo_q        <= lo_d;
      a_q         <= a_d;
      b_q         <= b_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      oidx_q      <= oidx_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_out) begin
      out_value_q <= rd_a_q;
      out_final_q <= status_o.emit_last;
    end
  end

  assign status_o.load_end   = (cnt_q == CW'(MAX_ELEMENTS - 1));
  assign status_o.single     = (cnt_q == CW'(1));
  assign status_o.group_last = ((WW'(k_q) + WW'(1)) == WW'(hi_q));
  assign status_o.pass_last  = (hi_q == cnt_q);
  assign status_o.sort_done  = ((w_w << 1) >= n_w);
  assign status_o.emit_last  = ((WW'(oidx_q) + WW'(1)) == n_w);
  assign status_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_final_o = out_final_q;

endmodule

`default_nettype wire

FILE: design/stable_merge_sorter_core.sv
// top level of the stable merge sorter: controller plus datapath
//
// usage
//   input stream: one signed 32-bit value per transfer on s_axis_tdata; tlast
//   marks the final element. a list also ends when MAX_ELEMENTS values are held.
//   output stream: the held values in ascending order, one per transfer on
//   m_axis_tdata; tlast is set on the final element. equal keys keep input order.
// operation
//   loading accepts one transfer per cycle; s_axis_tready is low from the
//   closing transfer until the last result is in the output register
//   sort: a setup step, then for each pass of width 1, 2, 4, ... a setup step
//   per group, and per element a memory read, then a compare and write
//   emit: each element is read through the registered read port, then loaded
//   into the output register
// reset
//   rst_ni is asynchronous, active low; the list is emptied and the block waits
//   for a new list. memory contents are not cleared
// back-pressure
//   a stalled receiver holds the output register and pauses emission; the next
//   list may start loading while the final result still waits to be taken
`timescale 1ns / 1ps
`default_nettype none

module stable_merge_sorter_core #(
  parameter int unsigned MAX_ELEMENTS = sms_pkg::MaxElements
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic        s_axis_tlast,   // last_item
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
  output logic             m_axis_tlast    // final_result
);

  sms_pkg::cmd_t    cmd;
  sms_pkg::status_t status;

  // sequencing of load, merge passes and emission
  sms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ping-pong element memory, run counters, comparator, output register
  sms_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (m_axis_tdata),
    .out_final_o (m_axis_tlast)
  );

endmodule

`default_nettype wire
